/* rtl/hdmm_pkg.sv */
// Shared constants for the hard-disk Metropolis move core.
// No dependencies; used by hard_disk_metropolis_move_core.
`default_nettype none

package hdmm_pkg;

    // Disk store depth and derived widths
    localparam int NUM_DISKS = 1024;
    localparam int IDX_W     = $clog2(NUM_DISKS);
    localparam int CNT_W     = $clog2(NUM_DISKS + 1);

    // Field widths fixed by the interface
    localparam int KIND_W  = 2;
    localparam int PART_W  = 10;
    localparam int COORD_W = 32;
    localparam int CFG_W   = 31;
    localparam int CIDX_W  = 2;

    // Request kinds (any other code reads)
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_BOX  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DIAM = 2'd1;
    localparam logic [CIDX_W-1:0] REG_STEP = 2'd2;

    // Reset values, Q16.16
    localparam logic [CFG_W-1:0] BOX_RESET  = 31'd8192000;
    localparam logic [CFG_W-1:0] DIAM_RESET = 31'd65536;
    localparam logic [CFG_W-1:0] STEP_RESET = 31'd6554;

endpackage

`default_nettype wire

/* rtl/hard_disk_metropolis_move_core.sv */
// Hard-disk Metropolis move core: disk position store plus trial/overlap sequencer.
// Depends on hdmm_pkg (constants, widths, request and register codes).
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   kind, particle, load_x, load_y,
//                                                  move_x_up, move_y_up
//   result    out        result_valid / result_stall  disk, pos_x, pos_y, accepted
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A trial sweeps each other disk; every axis whose offset is not below L also needs
// the bit-serial remainder. One store read per disk, one shared multiplier.
// An overlap ends the sweep early. Reset leaves the store unwritten (no clear pass).
// item_stall is high while a request is in work; a waiting result holds until taken.
`default_nettype none

module hard_disk_metropolis_move_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // request channel
    input  wire logic                                    item_valid,
    output logic                                         item_stall,
    input  wire logic [hdmm_pkg::KIND_W-1:0]             kind,
    input  wire logic [hdmm_pkg::PART_W-1:0]             particle,
    input  wire logic signed [hdmm_pkg::COORD_W-1:0]     load_x,
    input  wire logic signed [hdmm_pkg::COORD_W-1:0]     load_y,
    input  wire logic                                    move_x_up,
    input  wire logic                                    move_y_up,
    // result channel
    output logic                                         result_valid,
    input  wire logic                                    result_stall,
    output logic [hdmm_pkg::PART_W-1:0]                  disk,
    output logic signed [hdmm_pkg::COORD_W-1:0]          pos_x,
    output logic signed [hdmm_pkg::COORD_W-1:0]          pos_y,
    output logic                                         accepted,
    // configuration
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [hdmm_pkg::CIDX_W-1:0]             cfg_index,
    input  wire logic [hdmm_pkg::CFG_W-1:0]              cfg_data
);

    localparam int IDX_W   = hdmm_pkg::IDX_W;
    localparam int CNT_W   = hdmm_pkg::CNT_W;
    localparam int COORD_W = hdmm_pkg::COORD_W;
    localparam int CFG_W   = hdmm_pkg::CFG_W;
    localparam int PART_W  = hdmm_pkg::PART_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_TLIM   = 4'd2;
    localparam logic [3:0] S_MOVEX  = 4'd3;
    localparam logic [3:0] S_MOVEY  = 4'd4;
    localparam logic [3:0] S_FETCH  = 4'd5;
    localparam logic [3:0] S_REM    = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_FOLD   = 4'd8;
    localparam logic [3:0] S_SQ     = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_COMMIT = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    // Coordinate move with a single periodic wrap and 32-bit saturation
    function automatic logic signed [COORD_W-1:0] move_axis(
        input logic signed [COORD_W-1:0] c,
        input logic                      up,
        input logic [CFG_W-2:0]          half,
        input logic [CFG_W-1:0]          box
    );
        logic signed [34:0] cw;
        logic signed [34:0] hw;
        logic signed [34:0] lw;
        logic signed [34:0] n;
        logic signed [34:0] n2;
        logic signed [34:0] r;
        cw = $signed({{3{c[COORD_W-1]}}, c});
        hw = $signed({5'b0, half});
        lw = $signed({4'b0, box});
        n  = up ? (cw + hw) : (cw - hw);
        n2 = n <<< 1;
        if (n2 < -lw) begin
            r = n + lw;
        end else if (n2 > lw) begin
            r = n - lw;
        end else begin
            r = n;
        end
        if (r > 35'sd2147483647) begin
            r = 35'sd2147483647;
        end else if (r < -35'sd2147483648) begin
            r = -35'sd2147483648;
        end
        return r[COORD_W-1:0];
    endfunction

    // |a - b|; at most 2^32-1 for 32-bit operands
    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] m;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        m = d[COORD_W] ? -d : d;
        return m[COORD_W-1:0];
    endfunction

    // disk store
    logic signed [COORD_W-1:0] mem_x [hdmm_pkg::NUM_DISKS];
    logic signed [COORD_W-1:0] mem_y [hdmm_pkg::NUM_DISKS];
    logic signed [COORD_W-1:0] rd_x_reg;
    logic signed [COORD_W-1:0] rd_y_reg;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic signed [COORD_W-1:0] wr_x;
    logic signed [COORD_W-1:0] wr_y;
    logic [IDX_W-1:0]          rd_addr;

    // control
    logic [3:0]       state_reg, state_next;
    logic             result_valid_reg, result_valid_next;
    logic [CFG_W-1:0] box_reg, box_next;
    logic [CFG_W-1:0] diam_reg, diam_next;
    logic [CFG_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             axis_reg, axis_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             ok_reg, ok_next;

    // payload / datapath
    logic [PART_W-1:0]         part_reg, part_next;
    logic                      upx_reg, upx_next;
    logic                      upy_reg, upy_next;
    logic signed [COORD_W-1:0] oldx_reg, oldx_next;
    logic signed [COORD_W-1:0] oldy_reg, oldy_next;
    logic signed [COORD_W-1:0] nx_reg, nx_next;
    logic signed [COORD_W-1:0] ny_reg, ny_next;
    logic signed [COORD_W-1:0] ycur_reg, ycur_next;
    logic [COORD_W-1:0]        abs_reg, abs_next;
    logic [CFG_W-1:0]          rem_reg, rem_next;
    logic [COORD_W-1:0]        mag_reg, mag_next;
    logic [2*COORD_W-1:0]      prod_reg, prod_next;
    logic [2*CFG_W-1:0]        lim_reg, lim_next;
    logic [2*COORD_W-1:0]      sqx_reg, sqx_next;
    logic signed [COORD_W-1:0] resx_reg, resx_next;
    logic signed [COORD_W-1:0] resy_reg, resy_next;
    logic                      racc_reg, racc_next;
    logic [PART_W-1:0]         odisk_reg, odisk_next;
    logic signed [COORD_W-1:0] ox_reg, ox_next;
    logic signed [COORD_W-1:0] oy_reg, oy_next;
    logic                      oacc_reg, oacc_next;

    // shared units
    logic [COORD_W-1:0]        mul_a;
    logic [COORD_W-1:0]        mul_b;
    logic signed [COORD_W-1:0] mv_c;
    logic                      mv_up;
    logic signed [COORD_W-1:0] mv_out;
    logic [CFG_W:0]            div_t;
    logic                      div_ge;
    logic [2*COORD_W:0]        sum_sq;
    logic                      in_range_in;
    logic                      in_range;
    logic [CNT_W-1:0]          j_inc;
    logic                      j_last;
    logic                      j_self;

    assign mul_a  = (state_reg == S_TLIM) ? {1'b0, diam_reg} : mag_reg;
    assign mul_b  = mul_a;
    assign mv_c   = (state_reg == S_MOVEX) ? oldx_reg : oldy_reg;
    assign mv_up  = (state_reg == S_MOVEX) ? upx_reg : upy_reg;
    assign mv_out = move_axis(mv_c, mv_up, step_reg[CFG_W-1:1], box_reg);

    // one restoring remainder step
    assign div_t  = {rem_reg, abs_reg[cnt_reg]};
    assign div_ge = (div_t >= {1'b0, box_reg});

    assign sum_sq = {1'b0, sqx_reg} + {1'b0, prod_reg};

    assign in_range_in = (32'(particle) < 32'(hdmm_pkg::NUM_DISKS));
    assign in_range    = (32'(part_reg) < 32'(hdmm_pkg::NUM_DISKS));
    assign j_inc       = j_reg + CNT_W'(1);
    assign j_last      = (j_inc == CNT_W'(hdmm_pkg::NUM_DISKS));
    assign j_self      = (32'(j_reg) == 32'(part_reg));

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        box_next          = box_reg;
        diam_next         = diam_reg;
        step_next         = step_reg;
        j_next            = j_reg;
        axis_next         = axis_reg;
        cnt_next          = cnt_reg;
        ok_next           = ok_reg;
        part_next         = part_reg;
        upx_next          = upx_reg;
        upy_next          = upy_reg;
        oldx_next         = oldx_reg;
        oldy_next         = oldy_reg;
        nx_next           = nx_reg;
        ny_next           = ny_reg;
        ycur_next         = ycur_reg;
        abs_next          = abs_reg;
        rem_next          = rem_reg;
        mag_next          = mag_reg;
        prod_next         = prod_reg;
        lim_next          = lim_reg;
        sqx_next          = sqx_reg;
        resx_next         = resx_reg;
        resy_next         = resy_reg;
        racc_next         = racc_reg;
        odisk_next        = odisk_reg;
        ox_next           = ox_reg;
        oy_next           = oy_reg;
        oacc_next         = oacc_reg;
        wr_en             = 1'b0;
        wr_addr           = IDX_W'(part_reg);
        wr_x              = nx_reg;
        wr_y              = ny_reg;
        rd_addr           = j_reg[IDX_W-1:0];

        if (cfg_valid)
        begin
            unique case (cfg_index)
                hdmm_pkg::REG_BOX:  box_next  = cfg_data;
                hdmm_pkg::REG_DIAM: diam_next = cfg_data;
                hdmm_pkg::REG_STEP: step_next = cfg_data;
                default:            ;
            endcase
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    part_next = particle;
                    upx_next  = move_x_up;
                    upy_next  = move_y_up;
                    rd_addr   = IDX_W'(particle);
                    if (kind == hdmm_pkg::KIND_LOAD)
                    begin
                        wr_en      = in_range_in;
                        wr_addr    = IDX_W'(particle);
                        wr_x       = load_x;
                        wr_y       = load_y;
                        resx_next  = load_x;
                        resy_next  = load_y;
                        racc_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (kind == hdmm_pkg::KIND_TRIAL)
                    begin
                        resx_next  = '0;
                        resy_next  = '0;
                        racc_next  = 1'b0;
                        state_next = in_range_in ? S_TLIM : S_DONE;
                    end
                    else
                    begin
                        state_next = S_RDWAIT;
                    end
                end
            end

            S_RDWAIT:
            begin
                resx_next  = in_range ? rd_x_reg : '0;
                resy_next  = in_range ? rd_y_reg : '0;
                racc_next  = in_range;
                state_next = S_DONE;
            end

            S_TLIM:
            begin
                oldx_next  = rd_x_reg;
                oldy_next  = rd_y_reg;
                prod_next  = mul_a * mul_b;
                state_next = S_MOVEX;
            end

            S_MOVEX:
            begin
                lim_next   = prod_reg[2*CFG_W-1:0];
                nx_next    = mv_out;
                state_next = S_MOVEY;
            end

            S_MOVEY:
            begin
                ny_next    = mv_out;
                ok_next    = 1'b1;
                j_next     = '0;
                rd_addr    = '0;
                state_next = S_FETCH;
            end

            S_FETCH:
            begin
                if (j_self)
                begin
                    j_next     = j_inc;
                    rd_addr    = j_inc[IDX_W-1:0];
                    state_next = j_last ? S_COMMIT : S_FETCH;
                end
                else
                begin
                    ycur_next  = rd_y_reg;
                    abs_next   = abs_diff(nx_reg, rd_x_reg);
                    axis_next  = 1'b0;
                    state_next = S_REM;
                end
            end

            S_REM:
            begin
                if (box_reg == '0)
                begin
                    // no periodic image: plain distance
                    mag_next   = abs_reg;
                    state_next = S_SQ;
                end
                else if (abs_reg < {1'b0, box_reg})
                begin
                    rem_next   = abs_reg[CFG_W-1:0];
                    state_next = S_FOLD;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = 5'(COORD_W - 1);
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = div_ge ? CFG_W'(div_t - {1'b0, box_reg}) : div_t[CFG_W-1:0];
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FOLD;
                end
            end

            S_FOLD:
            begin
                // nearest image: distance is min(m, L - m)
                if ({rem_reg, 1'b0} > {1'b0, box_reg})
                begin
                    mag_next = {1'b0, box_reg - rem_reg};
                end
                else
                begin
                    mag_next = {1'b0, rem_reg};
                end
                state_next = S_SQ;
            end

            S_SQ:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_NEXT;
            end

            S_NEXT:
            begin
                if (!axis_reg)
                begin
                    sqx_next   = prod_reg;
                    abs_next   = abs_diff(ny_reg, ycur_reg);
                    axis_next  = 1'b1;
                    state_next = S_REM;
                end
                else if (sum_sq < {3'b0, lim_reg})
                begin
                    ok_next    = 1'b0;
                    state_next = S_COMMIT;
                end
                else
                begin
                    j_next     = j_inc;
                    rd_addr    = j_inc[IDX_W-1:0];
                    state_next = j_last ? S_COMMIT : S_FETCH;
                end
            end

            S_COMMIT:
            begin
                wr_en      = ok_reg;
                resx_next  = ok_reg ? nx_reg : oldx_reg;
                resy_next  = ok_reg ? ny_reg : oldy_reg;
                racc_next  = ok_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    odisk_next        = part_reg;
                    ox_next           = resx_reg;
                    oy_next           = resy_reg;
                    oacc_next         = racc_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            box_reg          <= hdmm_pkg::BOX_RESET;
            diam_reg         <= hdmm_pkg::DIAM_RESET;
            step_reg         <= hdmm_pkg::STEP_RESET;
            j_reg            <= '0;
            axis_reg         <= 1'b0;
            cnt_reg          <= '0;
            ok_reg           <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            box_reg          <= box_next;
            diam_reg         <= diam_next;
            step_reg         <= step_next;
            j_reg            <= j_next;
            axis_reg         <= axis_next;
            cnt_reg          <= cnt_next;
            ok_reg           <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg  <= part_next;
        upx_reg   <= upx_next;
        upy_reg   <= upy_next;
        oldx_reg  <= oldx_next;
        oldy_reg  <= oldy_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        ycur_reg  <= ycur_next;
        abs_reg   <= abs_next;
        rem_reg   <= rem_next;
        mag_reg   <= mag_next;
        prod_reg  <= prod_next;
        lim_reg   <= lim_next;
        sqx_reg   <= sqx_next;
        resx_reg  <= resx_next;
        resy_reg  <= resy_next;
        racc_reg  <= racc_next;
        odisk_reg <= odisk_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oacc_reg  <= oacc_next;
    end

    // position store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign disk         = odisk_reg;
    assign pos_x        = ox_reg;
    assign pos_y        = oy_reg;
    assign accepted     = oacc_reg;

endmodule

`default_nettype wire

/* verif/tb_hard_disk_metropolis_move_core.sv */
// Testbench for hard_disk_metropolis_move_core: fills the disk store, walks a directed table,
// then random requests under several box/diameter/step settings, checked against a predictor.
// Depends on hdmm_pkg and hard_disk_metropolis_move_core from rtl/.
`timescale 1ns / 100ps

module tb_hard_disk_metropolis_move_core;
    import hdmm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;   // unused code, behaves as a read

    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic [CFG_W-1:0]          CFG_TOP = {CFG_W{1'b1}};
    localparam longint COORD_HI = 64'sh7FFF_FFFF;
    localparam longint COORD_LO = -64'sh8000_0000;

    // 32 x 32 grid, centered in the reset box
    localparam int GRID_ORIGIN = -3968000;
    localparam int GRID_PITCH  = 256000;
    localparam int GRID_COLS   = 32;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [PART_W-1:0]         particle;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      up_x;
        logic                      up_y;
    } request_t;

    typedef struct packed {
        logic [PART_W-1:0]         disk;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      accepted;
    } disk_report_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

    // register rows carry the written value in rq.x
    typedef struct packed {
        row_kind_e         rk;
        logic [CIDX_W-1:0] reg_idx;
        request_t          rq;
        logic              typed;
        disk_report_t      want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [KIND_W-1:0] kind = '0;
    logic [PART_W-1:0] particle = '0;
    logic signed [COORD_W-1:0] load_x = '0;
    logic signed [COORD_W-1:0] load_y = '0;
    logic move_x_up = 1'b0;
    logic move_y_up = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [PART_W-1:0] disk;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic accepted;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // predictor state
    logic signed [COORD_W-1:0] stored_x [NUM_DISKS];
    logic signed [COORD_W-1:0] stored_y [NUM_DISKS];
    logic [CFG_W-1:0] box_len = BOX_RESET;
    logic [CFG_W-1:0] sigma = DIAM_RESET;
    logic [CFG_W-1:0] step_len = STEP_RESET;

    disk_report_t disk_reports [$];
    int mismatches = 0;
    bit no_idle = 1'b0;
    dir_row_t dir_rows [24];

    hard_disk_metropolis_move_core uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        result_stall <= !no_idle && ($urandom_range(0, 99) < 14);

    function automatic logic signed [COORD_W-1:0] moved_coord(
        input logic signed [COORD_W-1:0] c, input logic up, input longint half,
        input longint box);
        longint n;
        n = longint'(c) + (up ? half : -half);
        if (2 * n < -box)
            n = n + box;
        else if (2 * n > box)
            n = n - box;
        if (n > COORD_HI)
            n = COORD_HI;
        else if (n < COORD_LO)
            n = COORD_LO;
        return n[COORD_W-1:0];
    endfunction

    // squared minimum-image offset on one axis
    function automatic longint unsigned wrapped_dist_sq(
        input logic signed [COORD_W-1:0] a, b, input longint box);
        longint d;
        longint unsigned m;
        d = longint'(a) - longint'(b);
        if (box > 0)
        begin
            d = d % box;
            if (d < 0)
                d = d + box;
            if (2 * d > box)
                d = d - box;
        end
        m = (d < 0) ? -d : d;
        return m * m;
    endfunction

    function automatic disk_report_t apply_request(input request_t rq);
        disk_report_t rep;
        logic signed [COORD_W-1:0] nx, ny;
        longint box, half;
        longint unsigned lim, sx, sy, s;
        logic clear;
        box = longint'(box_len);
        half = longint'(step_len >> 1);
        lim = 64'(sigma) * 64'(sigma);
        rep.disk = rq.particle;
        rep.accepted = 1'b1;
        case (rq.kind)
            KIND_LOAD:
            begin
                stored_x[rq.particle] = rq.x;
                stored_y[rq.particle] = rq.y;
            end
            KIND_TRIAL:
            begin
                nx = moved_coord(stored_x[rq.particle], rq.up_x, half, box);
                ny = moved_coord(stored_y[rq.particle], rq.up_y, half, box);
                clear = 1'b1;
                for (int j = 0; j < NUM_DISKS; j++)
                begin
                    if (j != rq.particle)
                    begin
                        sx = wrapped_dist_sq(nx, stored_x[j], box);
                        sy = wrapped_dist_sq(ny, stored_y[j], box);
                        s = sx + sy;
                        if (s < sx)
                            s = '1;
                        if (s < lim)
                            clear = 1'b0;
                    end
                end
                if (clear)
                begin
                    stored_x[rq.particle] = nx;
                    stored_y[rq.particle] = ny;
                end
                rep.accepted = clear;
            end
            default: ;
        endcase
        rep.pos_x = stored_x[rq.particle];
        rep.pos_y = stored_y[rq.particle];
        return rep;
    endfunction

    function automatic dir_row_t item_row(input logic [KIND_W-1:0] k, input int p,
                                          input logic ux, input logic uy);
        dir_row_t row;
        row = '0;
        row.rk = ROW_ITEM;
        row.rq = '{k, p[PART_W-1:0], $urandom, $urandom, ux, uy};
        return row;
    endfunction

    // loads and reads whose answer is the position given
    function automatic dir_row_t typed_row(input logic [KIND_W-1:0] k, input int p,
                                           input logic signed [COORD_W-1:0] x, y);
        dir_row_t row;
        row = '0;
        row.rk = ROW_ITEM;
        row.rq = '{k, p[PART_W-1:0], x, y, 1'b0, 1'b0};
        row.typed = 1'b1;
        row.want = '{p[PART_W-1:0], x, y, 1'b1};
        return row;
    endfunction

    function automatic dir_row_t reg_row(input logic [CIDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        dir_row_t row;
        row = '0;
        row.rk = ROW_REG;
        row.reg_idx = idx;
        row.rq.x = {1'b0, val};
        return row;
    endfunction

    // item_valid is always lowered or reloaded in the step a request is taken
    task automatic wait_all_results();
        if (disk_reports.size() != 0)
        begin
            item_valid <= 1'b0;
            while (disk_reports.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic send_request(input request_t rq, input logic typed,
                                input disk_report_t want);
        disk_report_t outcome;
        cfg_valid <= 1'b0;
        while (!no_idle && $urandom_range(0, 99) < 14)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind <= rq.kind;
        particle <= rq.particle;
        load_x <= rq.x;
        load_y <= rq.y;
        move_x_up <= rq.up_x;
        move_y_up <= rq.up_y;
        do
            @(posedge clk);
        while (item_stall);
        outcome = apply_request(rq);
        disk_reports.push_back(typed ? want : outcome);
    endtask

    task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_BOX:  box_len = val;
            REG_DIAM: sigma = val;
            REG_STEP: step_len = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] box, diam, step);
        write_register(REG_BOX, box);
        write_register(REG_DIAM, diam);
        write_register(REG_STEP, step);
    endtask

    task automatic run_phase(input int count, input int trial_pct);
        request_t rq;
        int pick;
        int other;
        repeat (count)
        begin
            rq.particle = $urandom_range(0, NUM_DISKS - 1);
            rq.x = $urandom;
            rq.y = $urandom;
            rq.up_x = $urandom_range(0, 1);
            rq.up_y = $urandom_range(0, 1);
            pick = $urandom_range(0, 99);
            if (pick < trial_pct)
                rq.kind = KIND_TRIAL;
            else if (pick < trial_pct + 20)
                rq.kind = ($urandom_range(0, 5) == 0) ? KIND_SPARE : KIND_READ;
            else
            begin
                rq.kind = KIND_LOAD;
                pick = $urandom_range(0, 99);
                // mostly in-box, some crowding a neighbor, a few anywhere
                if (pick < 30)
                begin
                    other = $urandom_range(0, NUM_DISKS - 1);
                    rq.x = stored_x[other] + $urandom_range(0, 131072) - 65536;
                    rq.y = stored_y[other] + $urandom_range(0, 131072) - 65536;
                end
                else if (pick >= 38)
                begin
                    rq.x = $urandom_range(0, 8000000) - 4000000;
                    rq.y = $urandom_range(0, 8000000) - 4000000;
                end
            end
            if ($urandom_range(0, 99) < 3)
                wait_all_results();
            send_request(rq, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : check_reports
        disk_report_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            if (disk_reports.size() == 0)
            begin
                $error("unexpected result for disk %0d", disk);
                mismatches++;
            end
            else
            begin
                due = disk_reports.pop_front();
                if (disk !== due.disk)
                begin
                    $error("disk: expected %0d, got %0d", due.disk, disk);
                    mismatches++;
                end
                if (pos_x !== due.pos_x)
                begin
                    $error("pos_x: expected %0d, got %0d", due.pos_x, pos_x);
                    mismatches++;
                end
                if (pos_y !== due.pos_y)
                begin
                    $error("pos_y: expected %0d, got %0d", due.pos_y, pos_y);
                    mismatches++;
                end
                if (accepted !== due.accepted)
                begin
                    $error("accepted: expected %0d, got %0d", due.accepted, accepted);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #1_000_000_000;
        $display("hard_disk_metropolis_move_core: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        request_t rq;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // every disk gets a position before any trial sweeps the store
        for (int i = 0; i < NUM_DISKS; i++)
        begin
            rq.kind = KIND_LOAD;
            rq.particle = i;
            rq.x = GRID_ORIGIN + (i % GRID_COLS) * GRID_PITCH;
            rq.y = GRID_ORIGIN + (i / GRID_COLS) * GRID_PITCH;
            rq.up_x = $urandom_range(0, 1);
            rq.up_y = $urandom_range(0, 1);
            send_request(rq, 1'b0, '0);
        end

        dir_rows = '{
            typed_row(KIND_LOAD, 0, C_MIN, C_MAX),
            typed_row(KIND_READ, 0, C_MIN, C_MAX),
            item_row(KIND_TRIAL, 0, 1'b1, 1'b1),        // wraps on both axes
            typed_row(KIND_LOAD, 0, C_MAX, C_MIN),
            item_row(KIND_TRIAL, 0, 1'b0, 1'b0),
            // disk 1 sits 30000 from disk 2: both trials below overlap
            typed_row(KIND_LOAD, 1, -32'sd3426000, -32'sd3968000),
            item_row(KIND_TRIAL, 1, 1'b1, 1'b1),
            item_row(KIND_TRIAL, 2, 1'b0, 1'b0),
            typed_row(KIND_SPARE, 1, -32'sd3426000, -32'sd3968000),
            item_row(KIND_TRIAL, 5, 1'b0, 1'b1),
            item_row(KIND_READ, 5, 1'b0, 1'b0),
            reg_row(REG_STEP, CFG_TOP),
            reg_row(REG_BOX, '0),                        // no wrap, no image reduction
            typed_row(KIND_LOAD, 3, C_MAX, C_MAX),
            item_row(KIND_TRIAL, 3, 1'b1, 1'b1),        // saturates high
            typed_row(KIND_LOAD, 4, C_MIN, C_MIN),
            item_row(KIND_TRIAL, 4, 1'b0, 1'b0),        // saturates low
            reg_row(REG_BOX, CFG_TOP),
            reg_row(REG_DIAM, CFG_TOP),
            item_row(KIND_TRIAL, 6, 1'b1, 1'b0),        // everything overlaps
            reg_row(REG_DIAM, '0),
            item_row(KIND_TRIAL, 7, 1'b0, 1'b1),
            item_row(KIND_READ, 7, 1'b0, 1'b0),
            item_row(KIND_READ, NUM_DISKS - 1, 1'b0, 1'b0)
        };
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].rk == ROW_REG)
                write_register(dir_rows[i].reg_idx, dir_rows[i].rq.x[CFG_W-1:0]);
            else
                send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
        end

        // crowded: diameter close to the grid pitch, large steps
        set_geometry(BOX_RESET, 31'd196608, 31'd131072);
        run_phase(150, 35);
        set_geometry(CFG_TOP, $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 22));
        run_phase(110, 35);
        // zero box: every trial uses plain distances, no remainder step; keep them few
        set_geometry('0, DIAM_RESET, STEP_RESET);
        run_phase(25, 8);
        set_geometry($urandom_range(8192000, 33554432), 31'd131072, 31'd65536);
        run_phase(150, 30);
        set_geometry(BOX_RESET, DIAM_RESET, STEP_RESET);
        no_idle = 1'b1;
        run_phase(80, 35);
        no_idle = 1'b0;
        run_phase(65, 35);

        wait_all_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("hard_disk_metropolis_move_core: match");
        else
            $display("hard_disk_metropolis_move_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/hdmm_pkg.sv
rtl/hard_disk_metropolis_move_core.sv
verif/tb_hard_disk_metropolis_move_core.sv
